/* rtl/core/v4mt_pkg.sv */
// Package for the 4x4 matrix vertex transform: payload structs, fixed-point
// widths, register indexes and register reset values.
// No dependencies; every other file of the block uses it by scoped names.
`timescale 1ns / 1ps

package v4mt_pkg;

   // Fixed-point format of entries, components and results.
   localparam int FRAC_BITS = 16;
   localparam int Q_W       = 32;
   localparam int VEC_LEN   = 4;

   // Datapath widths: a full product, a pair sum and the four-term sum.
   localparam int PROD_W = 2 * Q_W;
   localparam int PAIR_W = PROD_W + 1;
   localparam int SUM_W  = PROD_W + 2;

   // Configuration port.
   localparam int CSR_W     = 64;
   localparam int NUM_REGS  = 8;
   localparam int CSR_IDX_W = 4;

   localparam logic [CSR_IDX_W-1:0] REG_ROW0_LEFT  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROW0_RIGHT = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROW1_LEFT  = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ROW1_RIGHT = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ROW2_LEFT  = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ROW2_RIGHT = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ROW3_LEFT  = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_ROW3_RIGHT = 4'd7;

   typedef logic signed [Q_W-1:0]    q_type;
   typedef q_type [VEC_LEN-1:0]      vec_type;
   typedef logic [CSR_W-1:0]         csr_word_type;
   typedef csr_word_type [NUM_REGS-1:0] csr_file_type;

   // The identity matrix: 1.0 on the diagonal, entry 2k low, 2k+1 high.
   localparam csr_word_type Q_ONE_LOW  = csr_word_type'(64'd1 << FRAC_BITS);
   localparam csr_word_type Q_ONE_HIGH = csr_word_type'(64'd1 << (FRAC_BITS + Q_W));
   localparam csr_file_type CSR_RESET  = '{
      Q_ONE_HIGH, csr_word_type'(0),   // row3_right, row3_left
      Q_ONE_LOW, csr_word_type'(0),    // row2_right, row2_left
      csr_word_type'(0), Q_ONE_HIGH,   // row1_right, row1_left
      csr_word_type'(0), Q_ONE_LOW     // row0_right, row0_left
   };

   // One vertex in, one transformed vertex out.
   typedef struct packed {
      logic signed [Q_W-1:0] in_x;
      logic signed [Q_W-1:0] in_y;
      logic signed [Q_W-1:0] in_z;
      logic signed [Q_W-1:0] in_w;
   } req_payload_type;

   typedef struct packed {
      logic signed [Q_W-1:0] out_x;
      logic signed [Q_W-1:0] out_y;
      logic signed [Q_W-1:0] out_z;
      logic signed [Q_W-1:0] out_w;
      logic                  overflow;
   } rsp_payload_type;

   // What one lane hands to the merging stage.
   typedef struct packed {
      q_type value;
      logic  sat;
   } lane_result_type;

endpackage

/* rtl/core/vec4_matrix_transform.sv */
// Data path: product, pair and sum registers of each lane, then the output register.
// Throughput: one vertex per clock, set by three lane stages and the output register,
// which all advance together; the pipeline holds only while a result is stalled.
// Reset (synchronous): all stage valid flags clear and the matrix loads identity.
// Top level of the 4x4 matrix vertex transform; depends on v4mt_pkg,
// v4mt_lane and v4mt_merge.
`timescale 1ns / 1ps

module vec4_matrix_transform (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  v4mt_pkg::req_payload_type          req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output v4mt_pkg::rsp_payload_type          rsp_data,
   input  logic                               csr_write_en,
   input  logic [v4mt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [v4mt_pkg::CSR_W-1:0]         csr_write_data
);

   v4mt_pkg::csr_file_type    csr_in;
   v4mt_pkg::csr_file_type    csr_ff;
   v4mt_pkg::vec_type         vertex;
   v4mt_pkg::vec_type         row_entries [v4mt_pkg::VEC_LEN];
   v4mt_pkg::lane_result_type lane_result [v4mt_pkg::VEC_LEN];
   logic                      pipe_advance;
   logic [2:0]                stage_valid_in;
   logic [2:0]                stage_valid_ff;
   logic                      rsp_valid_in;
   logic                      rsp_valid_ff;

   // Register write decode; indexes beyond the list are ignored.
   always_comb begin
      csr_in = csr_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            v4mt_pkg::REG_ROW0_LEFT:  csr_in[0] = csr_write_data;
            v4mt_pkg::REG_ROW0_RIGHT: csr_in[1] = csr_write_data;
            v4mt_pkg::REG_ROW1_LEFT:  csr_in[2] = csr_write_data;
            v4mt_pkg::REG_ROW1_RIGHT: csr_in[3] = csr_write_data;
            v4mt_pkg::REG_ROW2_LEFT:  csr_in[4] = csr_write_data;
            v4mt_pkg::REG_ROW2_RIGHT: csr_in[5] = csr_write_data;
            v4mt_pkg::REG_ROW3_LEFT:  csr_in[6] = csr_write_data;
            v4mt_pkg::REG_ROW3_RIGHT: csr_in[7] = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= v4mt_pkg::CSR_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // Split each pair of registers into the four entries of one matrix row.
   always_comb begin
      for (int r = 0; r < v4mt_pkg::VEC_LEN; r++) begin
         row_entries[r][0] = csr_ff[2*r][v4mt_pkg::Q_W-1:0];
         row_entries[r][1] = csr_ff[2*r][v4mt_pkg::CSR_W-1:v4mt_pkg::Q_W];
         row_entries[r][2] = csr_ff[2*r+1][v4mt_pkg::Q_W-1:0];
         row_entries[r][3] = csr_ff[2*r+1][v4mt_pkg::CSR_W-1:v4mt_pkg::Q_W];
      end
   end

   assign vertex[0] = req_data.in_x;
   assign vertex[1] = req_data.in_y;
   assign vertex[2] = req_data.in_z;
   assign vertex[3] = req_data.in_w;

   // The whole pipeline moves unless a finished result is being held back.
   assign pipe_advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall      = !pipe_advance;
   assign stage_valid_in = pipe_advance ? {stage_valid_ff[1:0], req_valid}
                                        : stage_valid_ff;
   assign rsp_valid_in   = pipe_advance ? stage_valid_ff[2] : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // One lane per matrix row.
   for (genvar r = 0; r < v4mt_pkg::VEC_LEN; r++) begin : g_lane
      v4mt_lane u_lane (
         .clock   (clock),
         .advance (pipe_advance),
         .row     (row_entries[r]),
         .vertex  (vertex),
         .result  (lane_result[r])
      );
   end

   v4mt_merge u_merge (
      .clock       (clock),
      .advance     (pipe_advance),
      .lane_result (lane_result),
      .rsp_data    (rsp_data)
   );

   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   // An accepted transaction enters the first stage.
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> stage_valid_ff[0])
      else $error("accepted transaction did not enter the pipeline");

   // A full last stage that advances always produces a result.
   a_last_to_out: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff[2] && pipe_advance) |=> rsp_valid_ff)
      else $error("result lost between last stage and output register");

   // The input is only held off while a result waits on the output.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall))
      else $error("input stalled without a held result");

   // While the output is held, the pipeline contents do not move.
   a_hold_stages: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(stage_valid_ff))
      else $error("pipeline moved while the output was stalled");
`endif

endmodule

/* rtl/core/v4mt_lane.sv */
// One row lane: four products, a pair-wise adder tree, rounding and saturation.
// Depends on v4mt_pkg.
`timescale 1ns / 1ps

module v4mt_lane (
   input  logic                      clock,
   input  logic                      advance,
   input  v4mt_pkg::vec_type         row,
   input  v4mt_pkg::vec_type         vertex,
   output v4mt_pkg::lane_result_type result
);

   localparam logic signed [v4mt_pkg::SUM_W-1:0] ROUND_HALF =
      v4mt_pkg::SUM_W'(1) <<< (v4mt_pkg::FRAC_BITS - 1);

   logic signed [v4mt_pkg::PROD_W-1:0] prod_in [v4mt_pkg::VEC_LEN];
   logic signed [v4mt_pkg::PROD_W-1:0] prod_ff [v4mt_pkg::VEC_LEN];
   logic signed [v4mt_pkg::PAIR_W-1:0] pair_in [2];
   logic signed [v4mt_pkg::PAIR_W-1:0] pair_ff [2];
   logic signed [v4mt_pkg::SUM_W-1:0]  sum_in;
   logic signed [v4mt_pkg::SUM_W-1:0]  sum_ff;
   logic signed [v4mt_pkg::SUM_W-1:0]  shifted;
   logic                               all_ones;
   logic                               all_zeros;

   // Stage one: each entry times its vertex component at full precision.
   always_comb begin
      for (int i = 0; i < v4mt_pkg::VEC_LEN; i++) begin
         prod_in[i] = v4mt_pkg::PROD_W'(row[i]) * v4mt_pkg::PROD_W'(vertex[i]);
      end
   end

   // Stage two: two pair sums; stage three: total plus half an LSB.
   assign pair_in[0] = v4mt_pkg::PAIR_W'(prod_ff[0]) + v4mt_pkg::PAIR_W'(prod_ff[1]);
   assign pair_in[1] = v4mt_pkg::PAIR_W'(prod_ff[2]) + v4mt_pkg::PAIR_W'(prod_ff[3]);
   assign sum_in     = v4mt_pkg::SUM_W'(pair_ff[0]) + v4mt_pkg::SUM_W'(pair_ff[1])
                       + ROUND_HALF;

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         pair_ff <= pair_in;
         sum_ff  <= sum_in;
      end
   end

   // Drop the fraction, then saturate when the bits above the result's sign
   // bit are not all copies of it.
   assign shifted   = sum_ff >>> v4mt_pkg::FRAC_BITS;
   assign all_ones  = &shifted[v4mt_pkg::SUM_W-1:v4mt_pkg::Q_W-1];
   assign all_zeros = ~|shifted[v4mt_pkg::SUM_W-1:v4mt_pkg::Q_W-1];

   always_comb begin
      result.sat = !(all_ones || all_zeros);
      if (!result.sat) begin
         result.value = shifted[v4mt_pkg::Q_W-1:0];
      end else if (shifted[v4mt_pkg::SUM_W-1]) begin
         result.value = {1'b1, {(v4mt_pkg::Q_W-1){1'b0}}};
      end else begin
         result.value = {1'b0, {(v4mt_pkg::Q_W-1){1'b1}}};
      end
   end

endmodule

/* rtl/core/v4mt_merge.sv */
// Merging stage: gathers the four lane results into the output register and
// folds their saturation flags into one overflow bit.
// Depends on v4mt_pkg.
`timescale 1ns / 1ps

module v4mt_merge (
   input  logic                      clock,
   input  logic                      advance,
   input  v4mt_pkg::lane_result_type lane_result [v4mt_pkg::VEC_LEN],
   output v4mt_pkg::rsp_payload_type rsp_data
);

   v4mt_pkg::rsp_payload_type rsp_data_in;
   v4mt_pkg::rsp_payload_type rsp_data_ff;

   // Pack the components and report any saturated lane.
   always_comb begin
      rsp_data_in.out_x    = lane_result[0].value;
      rsp_data_in.out_y    = lane_result[1].value;
      rsp_data_in.out_z    = lane_result[2].value;
      rsp_data_in.out_w    = lane_result[3].value;
      rsp_data_in.overflow = lane_result[0].sat || lane_result[1].sat
                             || lane_result[2].sat || lane_result[3].sat;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule
